// File: hdl/ffsa_pkg.sv
// Shared constants, codes and item type for the first-fit spectrum allocator.
package ffsa_pkg;

  localparam int LINKS_DEF  = 32;
  localparam int SLICES_DEF = 256;
  localparam int ROUTES_DEF = 16;

  localparam int MASK_W = 32;
  localparam int CNT_W  = 9;
  localparam int LEN_W  = 16;
  localparam int CFG_W  = 9;
  localparam int MISS_W = 16;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  typedef struct packed {
    logic              clear;
    logic              skip;
    logic              last;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  n;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

// File: hdl/ffsa_front.sv
// Front end: accepts input transactions, classifies them and queues them.
module ffsa_front import ffsa_pkg::*; #(
  parameter int SLICES = SLICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  slices_in_use,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // link_mask, slot_count, route_length, zero pad
  input  logic              in_tuser,   // op
  input  logic              in_tlast,   // last_route
  output logic              q_valid,
  input  logic              q_pop,
  output item_t             q_item
);

  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push;
  logic [CNT_W-1:0] n_in;

  assign n_in = in_tdata[MASK_W +: CNT_W];

  always_comb begin
    cls.clear = (in_tuser == OP_CLEAR);
    cls.last  = in_tlast;
    cls.mask  = in_tdata[MASK_W-1:0];
    cls.n     = n_in;
    cls.len   = in_tdata[MASK_W+CNT_W +: LEN_W];
    if (32'(slices_in_use) > SLICES) begin
      cls.skip = (n_in == '0) || (32'(n_in) > SLICES);
    end else begin
      cls.skip = (n_in == '0) || (n_in > slices_in_use);
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/ffsa_back.sv
// Back end: occupancy map, window search, candidate selection and commit.
module ffsa_back import ffsa_pkg::*; #(
  parameter int LINKS  = LINKS_DEF,
  parameter int SLICES = SLICES_DEF,
  parameter int ROUTES = ROUTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] slices_in_use,
  input  logic             q_valid,
  output logic             q_pop,
  input  item_t            q_item,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tuser
);

  localparam int SW = $clog2(SLICES + 1);
  localparam int SI = $clog2(SLICES);
  localparam int LI = $clog2(LINKS);
  localparam int RW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OR   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]        st_r, st_nxt;
  item_t             it_r;
  logic [SLICES-1:0] row_r [LINKS];
  logic [LINKS-1:0]  rv_r;
  logic [SLICES-1:0] used_r;
  logic [LI-1:0]     e_r;
  logic [SI-1:0]     s_r;
  logic [SW-1:0]     run_r;
  logic [SW-1:0]     lim;
  logic [SW-1:0]     nt_r, nt_nxt;
  logic [MISS_W-1:0] miss_r, miss_nxt;
  logic              cv_r;
  logic [SI-1:0]     cb_r, ce_r;
  logic [LEN_W-1:0]  cl_r;
  logic [MASK_W-1:0] ck_r;
  logic [RW-1:0]     ci_r, rc_r, rc_inc;
  logic [SLICES-1:0] win;
  logic [SW-1:0]     run_inc;
  logic              hit, any_link, commit, oval_r;
  logic [47:0]       odata_r;
  logic              ouser_r;

  assign lim = (32'(slices_in_use) > SLICES) ? SW'(SLICES) : SW'(slices_in_use);
  assign run_inc = run_r + SW'(1);
  assign hit = !used_r[s_r] && (32'(run_inc) == 32'(it_r.n));
  assign rc_inc = (32'(rc_r) == ROUTES - 1) ? '0 : rc_r + RW'(1);

  always_comb begin
    for (int i = 0; i < SLICES; i++) begin
      win[i] = (SI'(i) >= cb_r) && (SI'(i) <= ce_r);
    end
    any_link = 1'b0;
    for (int e = 0; e < LINKS; e++) begin
      if (e < MASK_W) begin
        any_link = any_link | ck_r[e];
      end
    end
  end

  assign q_pop  = (st_r == S_IDLE) && q_valid;
  assign commit = (st_r == S_FIN) && it_r.last && !(oval_r && !out_tready);

  always_comb begin
    nt_nxt   = nt_r;
    miss_nxt = miss_r;
    if (cv_r) begin
      if (any_link && (nt_r < SW'(ce_r) + SW'(1))) begin
        nt_nxt = SW'(ce_r) + SW'(1);
      end
    end else if (miss_r != '1) begin
      miss_nxt = miss_r + MISS_W'(1);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid && !q_item.clear) begin
          st_nxt = q_item.skip ? S_FIN : S_OR;
        end
      end
      S_OR: begin
        if (32'(e_r) == LINKS - 1) begin
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || (SW'(s_r) == lim - SW'(1))) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!it_r.last || commit) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r   <= q_item;
      used_r <= '0;
      e_r    <= '0;
    end
    if (st_r == S_OR) begin
      if (32'(e_r) < MASK_W && it_r.mask[e_r] && rv_r[e_r]) begin
        used_r <= used_r | row_r[e_r];
      end
      e_r   <= e_r + LI'(1);
      s_r   <= '0;
      run_r <= '0;
    end
    if (st_r == S_SCAN) begin
      run_r <= used_r[s_r] ? '0 : run_inc;
      s_r   <= s_r + SI'(1);
    end
    if (commit) begin
      for (int e = 0; e < LINKS; e++) begin
        if (e < MASK_W && cv_r && ck_r[e]) begin
          row_r[e] <= (rv_r[e] ? row_r[e] : '0) | win;
        end
      end
      odata_r <= {3'd0, miss_nxt, 9'(nt_nxt),
                  cv_r ? 4'(ci_r) : 4'd0,
                  cv_r ? 8'(ce_r) : 8'd0,
                  cv_r ? 8'(cb_r) : 8'd0};
      ouser_r <= cv_r;
    end
    if (st_r == S_SCAN && hit) begin
      if (!cv_r || ce_r > s_r || (ce_r == s_r && cl_r > it_r.len)) begin
        cb_r <= SI'(SW'(s_r) + SW'(1) - SW'(it_r.n));
        ce_r <= s_r;
        cl_r <= it_r.len;
        ck_r <= it_r.mask;
        ci_r <= rc_r;
      end
    end
    if (!rst_n) begin
      st_r   <= S_IDLE;
      rv_r   <= '0;
      nt_r   <= '0;
      miss_r <= '0;
      cv_r   <= 1'b0;
      rc_r   <= '0;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (commit) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
      if (q_pop && q_item.clear) begin
        rv_r   <= '0;
        nt_r   <= '0;
        miss_r <= '0;
        cv_r   <= 1'b0;
        rc_r   <= '0;
      end
      if (st_r == S_SCAN && hit) begin
        if (!cv_r || ce_r > s_r || (ce_r == s_r && cl_r > it_r.len)) begin
          cv_r <= 1'b1;
        end
      end
      if (st_r == S_FIN && !it_r.last) begin
        rc_r <= rc_inc;
      end
      if (commit) begin
        for (int e = 0; e < LINKS; e++) begin
          if (e < MASK_W && cv_r && ck_r[e]) begin
            rv_r[e] <= 1'b1;
          end
        end
        nt_r   <= nt_nxt;
        miss_r <= miss_nxt;
        cv_r   <= 1'b0;
        rc_r   <= '0;
      end
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

// File: hdl/first_fit_spectrum_allocator.sv
// Each route that is not skipped ORs one link row per cycle into a used map,
// then searches for a free window one slice per cycle; the last route commits.
// A new route or clear is taken only once the previous one is done. Results
// wait in an output register.
// Reset: synchronous active low; clears the map, counters and candidate and
// sets slices_in_use to 256.
module first_fit_spectrum_allocator import ffsa_pkg::*; #(
  parameter int LINKS  = LINKS_DEF,
  parameter int SLICES = SLICES_DEF,
  parameter int ROUTES = ROUTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // link_mask, slot_count, route_length, zero pad
  input  logic             in_tuser,   // op
  input  logic             in_tlast,   // last_route
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // begin_slice, end_slice, route_index,
                                       // max_slice_used, unserved_count, zero pad
  output logic             out_tuser   // found
);

  logic [CFG_W-1:0] siu_r;
  logic             q_valid, q_pop;
  item_t            q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= CFG_W'(256);
    end else if (cfg_valid) begin
      siu_r <= cfg_data;
    end
  end

  ffsa_front #(.SLICES(SLICES)) u_front (
    .clk(clk), .rst_n(rst_n), .slices_in_use(siu_r),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  ffsa_back #(.LINKS(LINKS), .SLICES(SLICES), .ROUTES(ROUTES)) u_back (
    .clk(clk), .rst_n(rst_n), .slices_in_use(siu_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[19:0] == 20'd0)
    else $error("unfound result carries a window");
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:8] >= out_tdata[7:0])
    else $error("committed window ends before it begins");
  a_pop_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
